>>> rtl/ghb_pkg.sv
`default_nettype none

package ghb_pkg;

   localparam int unsigned OP_WIDTH     = 2;
   localparam int unsigned PIXEL_WIDTH  = 8;
   localparam int unsigned BIN_WIDTH    = 8;
   localparam int unsigned HEIGHT_WIDTH = 10;

   // operation codes of a request word
   localparam logic [OP_WIDTH-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_READ  = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_CLEAR = 2'd2;

   localparam logic [HEIGHT_WIDTH-1:0] PLOT_HEIGHT_RESET = 10'd64;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

>>> rtl/ghb_if.sv
`default_nettype none

interface ghb_req_if;
   logic                                valid;
   logic                                ready;
   logic [ghb_pkg::OP_WIDTH-1:0]        operation;
   logic [ghb_pkg::PIXEL_WIDTH-1:0]     pixel_value;
   logic [ghb_pkg::BIN_WIDTH-1:0]       bin_index;

   modport source (output valid, operation, pixel_value, bin_index, input ready);
   modport sink   (input valid, operation, pixel_value, bin_index, output ready);
endinterface

interface ghb_rsp_if #(
   parameter int unsigned COUNT_WIDTH = 24
);
   logic                                valid;
   logic                                ready;
   logic [ghb_pkg::BIN_WIDTH-1:0]       bin_number;
   logic [COUNT_WIDTH-1:0]              bin_count;
   logic [ghb_pkg::HEIGHT_WIDTH-1:0]    bar_height;
   logic [COUNT_WIDTH-1:0]              peak_count;

   modport source (output valid, bin_number, bin_count, bar_height, peak_count,
                   input ready);
   modport sink   (input valid, bin_number, bin_count, bar_height, peak_count,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/ghb_bin_store.sv
`default_nettype none

// Bin count memory: one write port, one registered read port. A write that
// lands on the edge that captures a read of the same entry is forwarded.
module ghb_bin_store #(
   parameter int unsigned NUM_BINS    = 256,
   parameter int unsigned COUNT_WIDTH = 24,
   parameter int unsigned AW          = $clog2(NUM_BINS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   rd_en,
   input  wire logic [AW-1:0]          rd_addr,
   input  wire logic                   wr_en,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire logic [COUNT_WIDTH-1:0] wr_data,
   output logic      [COUNT_WIDTH-1:0] rd_data
);

   logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]          rd_addr_ff;
   logic                   fwd_valid_ff;
   logic [AW-1:0]          fwd_addr_ff;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= wr_en;
      end
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
   end

   assign rd_data = (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) ? fwd_data_ff : rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/ghb_div.sv
`default_nettype none

// Bar height unit: the load state multiplies count by plot height, then a
// restoring divide by the peak, one quotient bit per cycle.
module ghb_div #(
   parameter int unsigned COUNT_WIDTH = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [COUNT_WIDTH-1:0]              count,
   input  wire logic [ghb_pkg::HEIGHT_WIDTH-1:0]    plot_height,
   input  wire logic [COUNT_WIDTH-1:0]              peak,
   output ghb_pkg::div_status_type                  status,
   output logic      [ghb_pkg::HEIGHT_WIDTH-1:0]    quotient
);

   localparam int unsigned QW = ghb_pkg::HEIGHT_WIDTH;
   localparam int unsigned SW = $clog2(QW);
   localparam int unsigned PW = COUNT_WIDTH + QW;

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_LOAD = 2'd1;
   localparam logic [1:0] D_STEP = 2'd2;
   localparam logic [1:0] D_DONE = 2'd3;

   logic [1:0]             state_ff,  state_in;
   logic [SW-1:0]          step_ff,   step_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [QW-1:0]          height_ff;
   logic [COUNT_WIDTH-1:0] den_ff;
   logic [COUNT_WIDTH-1:0] rem_ff,    rem_in;
   logic [QW-1:0]          quo_ff,    quo_in;
   logic [PW-1:0]          product;
   logic [COUNT_WIDTH:0]   trial;
   logic [COUNT_WIDTH:0]   diff;

   assign product = PW'(count_ff) * PW'(height_ff);
   assign trial   = {rem_ff, quo_ff[QW-1]};
   assign diff    = trial - {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      case (state_ff)
         D_LOAD: begin
            // count <= peak, so the high part is already below the divisor
            rem_in   = product[PW-1:QW];
            quo_in   = product[QW-1:0];
            step_in  = '0;
            state_in = D_STEP;
         end
         D_STEP: begin
            if (!diff[COUNT_WIDTH]) begin
               rem_in = diff[COUNT_WIDTH-1:0];
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = trial[COUNT_WIDTH-1:0];
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
            if (step_ff == SW'(QW - 1)) begin
               state_in = D_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: ;
      endcase
      if (start) begin
         state_in = D_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      if (start) begin
         count_ff  <= count;
         height_ff <= plot_height;
         den_ff    <= peak;
      end
   end

   assign status.busy = (state_ff == D_LOAD) || (state_ff == D_STEP);
   assign status.done = (state_ff == D_DONE);
   // a zero peak reads as zero height
   assign quotient    = (den_ff == '0) ? '0 : quo_ff;

endmodule

`default_nettype wire

>>> rtl/gray_histogram_bar_heights_unit.sv
// An add word is counted from the processing slot register filled at acceptance;
// a read word gives its response word after memory read, multiply, bit-serial
// divide and output load. Throughput: one add word per cycle in the run state,
// set by the read-modify-write of the single bin memory; a read holds off the
// input until its response word is loaded, a clear until its pass ends. Reset
// (synchronous) runs a clearing pass over every bin of the bin memory and sets plot_height to 64.
`default_nettype none

module gray_histogram_bar_heights_unit #(
   parameter int unsigned NUM_BINS    = 256,
   parameter int unsigned COUNT_WIDTH = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ghb_req_if.sink                                  req_chan,
   ghb_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_write_enable,
   input  wire logic [ghb_pkg::HEIGHT_WIDTH-1:0]    csr_write_data
);

   localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int unsigned XW = (AW > ghb_pkg::BIN_WIDTH) ? AW : ghb_pkg::BIN_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = {COUNT_WIDTH{1'b1}};
   localparam logic [AW-1:0]          LAST_BIN    = AW'(NUM_BINS - 1);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_RUN    = 2'd1;
   localparam logic [1:0] S_DIVIDE = 2'd2;

   // control
   logic [1:0]                         state_ff, state_in;
   logic [AW-1:0]                      clr_addr_ff, clr_addr_in;
   logic                               req_accept;

   // registers
   logic [ghb_pkg::HEIGHT_WIDTH-1:0]   ph_ff;
   logic [COUNT_WIDTH-1:0]             peak_ff, peak_in;

   // word in flight, the cycle after acceptance
   logic                               p_valid_ff;
   logic [ghb_pkg::OP_WIDTH-1:0]       p_op_ff;
   logic [AW-1:0]                      p_addr_ff;
   logic                               p_in_range_ff;
   logic [ghb_pkg::BIN_WIDTH-1:0]      p_bin_ff;

   // read held while the divide runs
   logic [ghb_pkg::BIN_WIDTH-1:0]      h_bin_ff;
   logic [COUNT_WIDTH-1:0]             h_count_ff;
   logic [COUNT_WIDTH-1:0]             h_peak_ff;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ghb_pkg::BIN_WIDTH-1:0]      rsp_bin_ff;
   logic [COUNT_WIDTH-1:0]             rsp_count_ff;
   logic [ghb_pkg::HEIGHT_WIDTH-1:0]   rsp_height_ff;
   logic [COUNT_WIDTH-1:0]             rsp_peak_ff;
   logic                               rsp_load;

   // request decode
   logic [ghb_pkg::BIN_WIDTH-1:0]      sel_bin;
   logic [XW-1:0]                      sel_ext;
   logic                               sel_in_range;

   // memory ports
   logic                               wr_en;
   logic [AW-1:0]                      wr_addr;
   logic [COUNT_WIDTH-1:0]             wr_data;
   logic [COUNT_WIDTH-1:0]             store_rd;
   logic [COUNT_WIDTH-1:0]             cur_count;
   logic [COUNT_WIDTH-1:0]             next_count;

   // divider
   logic                               div_start;
   ghb_pkg::div_status_type            div_status;
   logic [ghb_pkg::HEIGHT_WIDTH-1:0]   div_quotient;

   // Take a word only in the run state, and hold off while a read or a clear
   // sits in the processing slot so it can redirect the state machine.
   assign req_chan.ready = (state_ff == S_RUN) &&
                           !(p_valid_ff && (p_op_ff != ghb_pkg::OP_ADD));
   assign req_accept     = req_chan.valid && req_chan.ready;

   // An add addresses its pixel's bin, a read its bin index.
   assign sel_bin      = (req_chan.operation == ghb_pkg::OP_ADD) ? req_chan.pixel_value
                                                                 : req_chan.bin_index;
   assign sel_ext      = XW'(sel_bin);
   assign sel_in_range = {1'b0, sel_ext} < (XW + 1)'(NUM_BINS);

   ghb_bin_store #(
      .NUM_BINS    (NUM_BINS),
      .COUNT_WIDTH (COUNT_WIDTH),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (sel_ext[AW-1:0]),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (store_rd)
   );

   // Out-of-range bins count as empty.
   assign cur_count  = p_in_range_ff ? store_rd : '0;
   assign next_count = cur_count + 1'b1;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      peak_in     = peak_ff;
      wr_en       = 1'b0;
      wr_addr     = p_addr_ff;
      wr_data     = next_count;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            // sweep zeros through the memory, one bin a cycle
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
            if (clr_addr_ff == LAST_BIN) begin
               state_in = S_RUN;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_RUN: begin
            if (p_valid_ff) begin
               case (p_op_ff)
                  ghb_pkg::OP_ADD: begin
                     // saturate: a full bin stays put and leaves the peak alone
                     if (p_in_range_ff && (cur_count != COUNT_LIMIT)) begin
                        wr_en = 1'b1;
                        if (next_count > peak_ff) begin
                           peak_in = next_count;
                        end
                     end
                  end
                  ghb_pkg::OP_READ: begin
                     div_start = 1'b1;
                     state_in  = S_DIVIDE;
                  end
                  ghb_pkg::OP_CLEAR: begin
                     peak_in     = '0;
                     clr_addr_in = '0;
                     state_in    = S_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         S_DIVIDE: begin
            // wait for the quotient and a free output register
            if (div_status.done && (!rsp_valid_ff || rsp_chan.ready)) begin
               rsp_load = 1'b1;
               state_in = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   ghb_div #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .count       (cur_count),
      .plot_height (ph_ff),
      .peak        (peak_ff),
      .status      (div_status),
      .quotient    (div_quotient)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         peak_ff      <= '0;
         ph_ff        <= ghb_pkg::PLOT_HEIGHT_RESET;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         peak_ff      <= peak_in;
         p_valid_ff   <= req_accept;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            ph_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         p_op_ff       <= req_chan.operation;
         p_addr_ff     <= sel_ext[AW-1:0];
         p_in_range_ff <= sel_in_range;
         p_bin_ff      <= req_chan.bin_index;
      end
      if (div_start) begin
         h_bin_ff   <= p_bin_ff;
         h_count_ff <= cur_count;
         h_peak_ff  <= peak_ff;
      end
      if (rsp_load) begin
         rsp_bin_ff    <= h_bin_ff;
         rsp_count_ff  <= h_count_ff;
         rsp_height_ff <= div_quotient;
         rsp_peak_ff   <= h_peak_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.bin_number = rsp_bin_ff;
   assign rsp_chan.bin_count  = rsp_count_ff;
   assign rsp_chan.bar_height = rsp_height_ff;
   assign rsp_chan.peak_count = rsp_peak_ff;

   // the peak never falls below a count just written by an add
   a_peak_covers_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && wr_en) |=> (peak_ff >= $past(wr_data)))
      else $error("peak below a written bin count");

   // a bar never rises above the plot height
   a_height_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_chan.bar_height <= ph_ff))
      else $error("bar height above plot height");

   // the divider only runs while a read waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> (state_ff == S_DIVIDE))
      else $error("divider busy outside divide state");

   // the peak stays zero and no word is taken while the memory is being cleared
   a_clear_peak: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (peak_ff == '0 && !req_accept))
      else $error("activity during clearing pass");

endmodule

`default_nettype wire
